@@ src/cramer_3x3_solver_defines.svh @@
// Assertion macros used by the checker file of the 3x3 solver.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CRAMER_3X3_SOLVER_DEFINES_SVH
`define CRAMER_3X3_SOLVER_DEFINES_SVH

// implication checked outside reset
`define C3S_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c3s check failed");

// next-cycle implication checked at every edge, reset included
`define C3S_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("c3s check failed");

`endif

@@ src/c3s_pkg.sv @@
// Shared widths and latencies for the 3x3 Cramer solver.
// No dependencies.
package c3s_pkg;
    localparam int ORDER     = 3;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int MINOR_W   = 2 * DATA_W + 1;
    localparam int DET_W     = 100;
    localparam int QBITS     = DATA_W + 1;
    localparam int FRONT_LAT = 5;
    localparam int DIV_LAT   = QBITS + 2;
    localparam int LATENCY   = FRONT_LAT + DIV_LAT;
endpackage

@@ src/c3s_div.sv @@
// Pipelined restoring divider: (num * 2^16) / den, truncated, saturated to Q16.16.
// Depends on c3s_pkg. One quotient bit per stage, one new division per cycle.
module c3s_div (
    input  logic                                i_clk,
    input  logic signed [c3s_pkg::DET_W-1:0]    i_num,
    input  logic signed [c3s_pkg::DET_W-1:0]    i_den,
    output logic        [c3s_pkg::DATA_W-1:0]   o_quo,
    output logic                                o_sat
);
    import c3s_pkg::*;

    localparam int NW = DET_W + FRAC_W;
    localparam int CW = NW + QBITS;

    logic [NW-1:0]    r_rem [0:QBITS];
    logic [DET_W-1:0] r_den [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic [QBITS:0]   r_neg;
    logic [QBITS:0]   r_ovf;

    logic [DET_W-1:0] n_abs_num;
    logic [DET_W-1:0] n_abs_den;
    logic [NW-1:0]    n_num_sh;

    always_comb begin
        n_abs_num = i_num[DET_W-1] ? DET_W'(-i_num) : DET_W'(i_num);
        n_abs_den = i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
        n_num_sh  = {n_abs_num, {FRAC_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_num_sh;
        r_den[0] <= n_abs_den;
        r_q[0]   <= '0;
        r_neg[0] <= i_num[DET_W-1] ^ i_den[DET_W-1];
        // quotient of 2^33 or more cannot be held by the bit stages
        r_ovf[0] <= CW'(n_num_sh) >= (CW'(n_abs_den) << QBITS);
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        logic [CW-1:0] n_trial;
        logic          n_ge;
        always_comb begin
            n_trial = CW'(r_den[k]) << (QBITS - 1 - k);
            n_ge    = CW'(r_rem[k]) >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? NW'(CW'(r_rem[k]) - n_trial) : r_rem[k];
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= {r_q[k][QBITS-2:0], n_ge};
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    logic [QBITS-1:0]  n_limit;
    logic              n_sat;
    logic [DATA_W-1:0] n_quo;

    always_comb begin
        n_limit = r_neg[QBITS] ? (QBITS'(1) << (DATA_W - 1))
                               : ((QBITS'(1) << (DATA_W - 1)) - QBITS'(1));
        n_sat   = r_ovf[QBITS] | (r_q[QBITS] > n_limit);
        if (n_sat) begin
            n_quo = r_neg[QBITS] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else if (r_neg[QBITS]) begin
            n_quo = -r_q[QBITS][DATA_W-1:0];
        end else begin
            n_quo = r_q[QBITS][DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_quo <= n_quo;
        o_sat <= n_sat;
    end
endmodule

@@ src/cramer_3x3_solver.sv @@
// 3x3 linear solver by Cramer's rule, Q16.16 in and out.
// Depends on c3s_pkg and c3s_div.
//
// Takes one system per clock: busy stays low and an item is taken whenever
// start is high. Each result reaches o_valid through 5 determinant stages
// and then the 35-stage quotient pipeline, whose bit stages each form one
// quotient bit. The receiver cannot stall; results come out in item order,
// one strobe cycle each.
module cramer_3x3_solver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r1c1,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r1c2,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r1c3,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r2c1,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r2c2,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r2c3,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r3c1,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r3c2,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_coef_r3c3,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_rhs_1,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_rhs_2,
    input  logic signed [c3s_pkg::DATA_W-1:0]  i_rhs_3,
    output logic                               o_valid,
    output logic signed [c3s_pkg::DATA_W-1:0]  o_solution_1,
    output logic signed [c3s_pkg::DATA_W-1:0]  o_solution_2,
    output logic signed [c3s_pkg::DATA_W-1:0]  o_solution_3,
    output logic                               o_singular,
    output logic                               o_saturated
);
    import c3s_pkg::*;

    localparam int PW = 2 * DATA_W;

    // row-1 operands: a11, a12, a13, b1
    logic signed [DATA_W-1:0]  r_x1 [0:3];
    logic signed [DATA_W-1:0]  r_x2 [0:3];
    logic signed [PW-1:0]      r_p  [0:11];
    logic signed [MINOR_W-1:0] r_m  [0:5];
    logic signed [MINOR_W-1:0] r_pl [0:11];
    logic signed [MINOR_W-1:0] r_ph [0:11];
    logic signed [DET_W-1:0]   r_t  [0:11];
    logic signed [DET_W-1:0]   r_det[0:3];
    logic [FRONT_LAT-1:0]      r_vld;
    logic [DIV_LAT-1:0]        r_dvld;
    logic [DIV_LAT-1:0]        r_dsng;

    // stage 1: 2x2 products of rows 2 and 3
    always_ff @(posedge i_clk) begin
        r_p[0]  <= i_coef_r2c2 * i_coef_r3c3;
        r_p[1]  <= i_coef_r3c2 * i_coef_r2c3;
        r_p[2]  <= i_coef_r2c1 * i_coef_r3c3;
        r_p[3]  <= i_coef_r3c1 * i_coef_r2c3;
        r_p[4]  <= i_coef_r2c1 * i_coef_r3c2;
        r_p[5]  <= i_coef_r3c1 * i_coef_r2c2;
        r_p[6]  <= i_rhs_2 * i_coef_r3c3;
        r_p[7]  <= i_coef_r2c3 * i_rhs_3;
        r_p[8]  <= i_rhs_2 * i_coef_r3c2;
        r_p[9]  <= i_coef_r2c2 * i_rhs_3;
        r_p[10] <= i_coef_r2c1 * i_rhs_3;
        r_p[11] <= i_rhs_2 * i_coef_r3c1;
        r_x1[0] <= i_coef_r1c1;
        r_x1[1] <= i_coef_r1c2;
        r_x1[2] <= i_coef_r1c3;
        r_x1[3] <= i_rhs_1;
    end

    // stage 2: minors; stage 3: minor times row-1 operand as two partial products
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 6; j++) begin
            r_m[j] <= MINOR_W'(r_p[2*j]) - MINOR_W'(r_p[2*j+1]);
        end
        r_x2 <= r_x1;
    end

    // product map: {row-1 operand, minor} per term; minors M1 M2 M3 P Q R
    logic [1:0] n_xs [0:11];
    logic [2:0] n_ms [0:11];
    always_comb begin
        n_xs = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
        n_ms = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd3, 3'd4, 3'd3, 3'd1, 3'd5, 3'd4, 3'd5, 3'd2};
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 12; j++) begin
            r_pl[j] <= $signed({1'b0, r_m[n_ms[j]][DATA_W-1:0]}) * r_x2[n_xs[j]];
            r_ph[j] <= $signed(r_m[n_ms[j]][MINOR_W-1:DATA_W]) * r_x2[n_xs[j]];
        end
    end

    // stage 4: join partial products; stage 5: signed sums into determinants
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 12; j++) begin
            r_t[j] <= (DET_W'(r_ph[j]) <<< DATA_W) + DET_W'(r_pl[j]);
        end
        r_det[0] <= r_t[0] - r_t[1] + r_t[2];
        r_det[1] <= r_t[3] - r_t[4] + r_t[5];
        r_det[2] <= r_t[6] - r_t[7] + r_t[8];
        r_det[3] <= r_t[11] - r_t[9] - r_t[10];
    end

    logic [DATA_W-1:0] n_quo [0:ORDER-1];
    logic [ORDER-1:0]  n_sat;

    for (genvar k = 0; k < ORDER; k++) begin : g_div
        c3s_div u_div (
            .i_clk (i_clk),
            .i_num (r_det[k+1]),
            .i_den (r_det[0]),
            .o_quo (n_quo[k]),
            .o_sat (n_sat[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_dvld <= '0;
        end else begin
            r_vld  <= {r_vld[FRONT_LAT-2:0], start};
            r_dvld <= {r_dvld[DIV_LAT-2:0], r_vld[FRONT_LAT-1]};
        end
        r_dsng <= {r_dsng[DIV_LAT-2:0], r_det[0] == '0};
    end

    assign busy         = 1'b0;
    assign o_valid      = r_dvld[DIV_LAT-1];
    assign o_singular   = r_dsng[DIV_LAT-1];
    assign o_saturated  = !r_dsng[DIV_LAT-1] && (|n_sat);
    assign o_solution_1 = r_dsng[DIV_LAT-1] ? '0 : $signed(n_quo[0]);
    assign o_solution_2 = r_dsng[DIV_LAT-1] ? '0 : $signed(n_quo[1]);
    assign o_solution_3 = r_dsng[DIV_LAT-1] ? '0 : $signed(n_quo[2]);
endmodule

@@ src/c3s_checker.sv @@
// Port-level checks for the 3x3 Cramer solver, bound to the top level.
// Depends on c3s_pkg and cramer_3x3_solver_defines.svh.
`include "cramer_3x3_solver_defines.svh"
module c3s_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic [c3s_pkg::DATA_W-1:0]        o_solution_1,
    input logic [c3s_pkg::DATA_W-1:0]        o_solution_2,
    input logic [c3s_pkg::DATA_W-1:0]        o_solution_3,
    input logic                              o_singular,
    input logic                              o_saturated
);
    import c3s_pkg::*;

    logic all_zero;
    assign all_zero = (o_solution_1 | o_solution_2 | o_solution_3) == '0;

    // every result traces back to an item a fixed time earlier
    `C3S_ASSERT_IMP(a_latency, o_valid, $past(start, LATENCY) && !$past(busy, LATENCY))
    // singular systems report zero and no clipping
    `C3S_ASSERT_IMP(a_singular, o_valid && o_singular, all_zero && !o_saturated)
    // reset drains the pipeline
    `C3S_ASSERT_NXT(a_reset, !i_rst_n, !o_valid)
endmodule

bind cramer_3x3_solver c3s_checker u_c3s_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_solution_1 (o_solution_1),
    .o_solution_2 (o_solution_2),
    .o_solution_3 (o_solution_3),
    .o_singular   (o_singular),
    .o_saturated  (o_saturated)
);

@@ verif/tb_cramer_3x3_solver.sv @@
// Self-checking testbench for the 3x3 Cramer solver: directed table, then random systems.
// Depends on c3s_pkg and the cramer_3x3_solver RTL; predicts untyped and random results with
// exact 128-bit determinants and compares every result with the result strobe.
`timescale 1ns / 1ps

module tb_cramer_3x3_solver;
    import c3s_pkg::*;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_word cf[9];
        t_word rh[3];
    } t_system;

    typedef struct {
        t_word sol[3];
        logic  singular;
        logic  saturated;
    } t_solution;

    typedef struct {
        t_system   sys;
        logic      typed;
        t_solution want;
    } t_dir_row;

    localparam int    NUM_RANDOM = 1550;
    localparam int    CYCLE_LIMIT = 200000;
    localparam t_wide Q_MAX = 128'sh7FFFFFFF;
    localparam t_wide Q_MIN = -128'sh80000000;
    localparam t_word ONE = 32'sh0001_0000;
    localparam t_word W_MAX = 32'sh7FFF_FFFF;
    localparam t_word W_MIN = 32'sh8000_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_word i_coef_r1c1 = '0, i_coef_r1c2 = '0, i_coef_r1c3 = '0;
    t_word i_coef_r2c1 = '0, i_coef_r2c2 = '0, i_coef_r2c3 = '0;
    t_word i_coef_r3c1 = '0, i_coef_r3c2 = '0, i_coef_r3c3 = '0;
    t_word i_rhs_1 = '0, i_rhs_2 = '0, i_rhs_3 = '0;
    logic  o_valid;
    t_word o_solution_1, o_solution_2, o_solution_3;
    logic  o_singular, o_saturated;

    t_solution pending_solutions[$];
    t_dir_row  dir_tab[$];
    int        error_count = 0;
    int        cycle_count = 0;

    cramer_3x3_solver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_r1c1(i_coef_r1c1), .i_coef_r1c2(i_coef_r1c2), .i_coef_r1c3(i_coef_r1c3),
        .i_coef_r2c1(i_coef_r2c1), .i_coef_r2c2(i_coef_r2c2), .i_coef_r2c3(i_coef_r2c3),
        .i_coef_r3c1(i_coef_r3c1), .i_coef_r3c2(i_coef_r3c2), .i_coef_r3c3(i_coef_r3c3),
        .i_rhs_1(i_rhs_1), .i_rhs_2(i_rhs_2), .i_rhs_3(i_rhs_3),
        .o_valid(o_valid), .o_solution_1(o_solution_1), .o_solution_2(o_solution_2),
        .o_solution_3(o_solution_3), .o_singular(o_singular), .o_saturated(o_saturated)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_wide det3(input t_word m[9]);
        t_wide e[9];
        for (int i = 0; i < 9; i++) e[i] = m[i];
        return e[0] * (e[4] * e[8] - e[5] * e[7])
             - e[1] * (e[3] * e[8] - e[5] * e[6])
             + e[2] * (e[3] * e[7] - e[4] * e[6]);
    endfunction

    function automatic t_solution solve_system(input t_system s);
        t_solution r;
        t_word     m[9];
        t_wide     d;
        t_wide     q;
        r.singular = 1'b0;
        r.saturated = 1'b0;
        d = det3(s.cf);
        if (d == 0) begin
            r.sol = '{default: '0};
            r.singular = 1'b1;
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            m = s.cf;
            for (int row = 0; row < 3; row++) m[row * 3 + k] = s.rh[row];
            // signed division truncates toward zero
            q = (det3(m) <<< FRAC_W) / d;
            if (q > Q_MAX) begin
                r.sol[k] = W_MAX;
                r.saturated = 1'b1;
            end else if (q < Q_MIN) begin
                r.sol[k] = W_MIN;
                r.saturated = 1'b1;
            end else begin
                r.sol[k] = q[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_system diag_system(input t_word dg, input t_word r0, r1, r2);
        t_system s;
        s.cf = '{default: '0};
        s.cf[0] = dg;
        s.cf[4] = dg;
        s.cf[8] = dg;
        s.rh = '{r0, r1, r2};
        return s;
    endfunction

    function automatic t_word rand_word();
        return t_word'($urandom);
    endfunction

    function automatic t_word rand_small();
        return t_word'((int'($urandom_range(0, 16)) - 8) * 65536 + int'($urandom_range(0, 65535)));
    endfunction

    function automatic t_system rand_system();
        t_system s;
        int      pick;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++) s.cf[i] = (pick < 40) ? rand_word() : rand_small();
        for (int i = 0; i < 3; i++) s.rh[i] = (pick < 40 || pick >= 90) ? rand_word()
                                                                        : rand_small();
        if (pick >= 55 && pick < 70) begin
            // copy a row so the matrix drops rank
            for (int c = 0; c < 3; c++) s.cf[6 + c] = s.cf[c];
        end else if (pick >= 70) begin
            for (int i = 0; i < 3; i++) s.cf[i * 4] = t_word'(32'sh0020_0000) + rand_small();
        end
        return s;
    endfunction

    task automatic add_row(input t_system s, input logic typed, input t_solution want);
        t_dir_row row;
        row.sys = s;
        row.typed = typed;
        row.want = want;
        dir_tab.push_back(row);
    endtask

    task automatic send_system(input t_system s, input t_solution want, input logic idle_on);
        while (idle_on && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        {i_coef_r1c1, i_coef_r1c2, i_coef_r1c3} <= {s.cf[0], s.cf[1], s.cf[2]};
        {i_coef_r2c1, i_coef_r2c2, i_coef_r2c3} <= {s.cf[3], s.cf[4], s.cf[5]};
        {i_coef_r3c1, i_coef_r3c2, i_coef_r3c3} <= {s.cf[6], s.cf[7], s.cf[8]};
        {i_rhs_1, i_rhs_2, i_rhs_3} <= {s.rh[0], s.rh[1], s.rh[2]};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_solutions.push_back(want);
    endtask

    initial begin
        t_solution sing;
        t_solution w;
        t_system   s;
        sing.sol = '{default: '0};
        sing.singular = 1'b1;
        sing.saturated = 1'b0;

        // zero, all-max and all-min matrices are singular
        s = diag_system('0, W_MAX, W_MIN, ONE);
        add_row(s, 1'b1, sing);
        s.cf = '{default: W_MAX};
        add_row(s, 1'b1, sing);
        s.cf = '{default: W_MIN};
        add_row(s, 1'b1, sing);
        // identity passes the right-hand vector through
        w.singular = 1'b0;
        w.saturated = 1'b0;
        w.sol = '{W_MAX, W_MIN, 32'sh0};
        add_row(diag_system(ONE, W_MAX, W_MIN, 32'sh0), 1'b1, w);
        w.sol = '{32'shFFFF_FFFF, 32'sh1, ONE};
        add_row(diag_system(ONE, 32'shFFFF_FFFF, 32'sh1, ONE), 1'b1, w);
        // tiny diagonal drives the quotient past both ends
        w.saturated = 1'b1;
        w.sol = '{W_MAX, W_MIN, 32'sh0};
        add_row(diag_system(32'sh1, W_MAX, W_MIN, 32'sh0), 1'b1, w);
        // minus one on the diagonal: the most negative value flips out of range
        w.sol = '{W_MAX, 32'sh8000_0001, ONE};
        add_row(diag_system(-ONE, W_MIN, W_MAX, -ONE), 1'b1, w);
        add_row(diag_system(W_MAX, W_MAX, W_MIN, 32'sh1), 1'b0, w);
        add_row(diag_system(W_MIN, W_MAX, W_MIN, W_MIN), 1'b0, w);
        for (int i = 0; i < 12; i++) add_row(rand_system(), 1'b0, w);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_system(dir_tab[i].sys,
                        dir_tab[i].typed ? dir_tab[i].want : solve_system(dir_tab[i].sys),
                        1'b1);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            s = rand_system();
            // long stretch with no idling in the middle
            send_system(s, solve_system(s), !(n >= 500 && n < 900));
        end
        start <= 1'b0;

        wait (pending_solutions.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_solution want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_solutions.size() == 0) begin
                $display("%0t: result with no item outstanding", $time);
                error_count <= error_count + 1;
            end else begin
                want = pending_solutions.pop_front();
                if (o_solution_1 !== want.sol[0] || o_solution_2 !== want.sol[1] ||
                    o_solution_3 !== want.sol[2] || o_singular !== want.singular ||
                    o_saturated !== want.saturated) begin
                    $display("%0t: expected %h %h %h sing %b sat %b, got %h %h %h sing %b sat %b",
                             $time, want.sol[0], want.sol[1], want.sol[2], want.singular,
                             want.saturated, o_solution_1, o_solution_2, o_solution_3,
                             o_singular, o_saturated);
                    error_count <= error_count + 1;
                end
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+src
src/c3s_pkg.sv
src/c3s_div.sv
src/cramer_3x3_solver.sv
src/c3s_checker.sv
verif/tb_cramer_3x3_solver.sv
